FILE: sv/complex_arith_unit_macros.svh
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is high.
`define CAU_ASSERT_CLK(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) expr) \
      else $error("complex_arith_unit check failed");
// Clocked check that also runs during reset.
`define CAU_ASSERT_RST(label, expr) \
   label: assert property (@(posedge clock) expr) \
      else $error("complex_arith_unit reset check failed");
`else
`define CAU_ASSERT_CLK(label, expr)
`define CAU_ASSERT_RST(label, expr)
`endif
`endif

FILE: sv/cau_pkg.sv
// Shared types, codes and constants of the complex arithmetic unit.
package cau_pkg;
   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int REM_W     = PROD_W;
   localparam int DIV_STEPS = DATA_W;

   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SAT      = 2'd1,
      STATUS_DIV_ZERO = 2'd2
   } status_type;

   // One part of a division in flight.
   typedef struct packed {
      logic              neg;
      logic              big;
      logic [REM_W-1:0]  rem;
      logic [DATA_W-1:0] low;
      logic [DATA_W-1:0] q;
   } lane_type;

   // Request state carried through the divider stages.
   typedef struct packed {
      logic              is_div;
      logic              div_zero;
      logic [DATA_W-1:0] fwd_re;
      logic [DATA_W-1:0] fwd_im;
      logic              fwd_sat;
      logic [REM_W-1:0]  den;
      lane_type          re;
      lane_type          im;
   } div_pipe_type;
endpackage

FILE: sv/cau_req_if.sv
// Request channel of the complex arithmetic unit.
interface cau_req_if;
   import cau_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               command;
   logic signed [DATA_W-1:0] a_re;
   logic signed [DATA_W-1:0] a_im;
   logic signed [DATA_W-1:0] b_re;
   logic signed [DATA_W-1:0] b_im;

   modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

FILE: sv/cau_rsp_if.sv
// Response channel of the complex arithmetic unit.
interface cau_rsp_if;
   import cau_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] res_re;
   logic signed [DATA_W-1:0] res_im;
   logic [1:0]               status;

   modport source (output valid, res_re, res_im, status, input ready);
   modport sink (input valid, res_re, res_im, status, output ready);
endinterface

FILE: sv/cau_div_stage.sv
// One registered restoring-division stage: one quotient bit for each part.
module cau_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  cau_pkg::div_pipe_type up_data,
   output logic                  down_valid,
   input  logic                  down_ready,
   output cau_pkg::div_pipe_type down_data
);
   import cau_pkg::*;

   logic         valid_ff;
   div_pipe_type data_ff;
   div_pipe_type data_in;

   // Shift in the next dividend bit and subtract the divisor when it fits.
   function automatic lane_type step(lane_type l, logic [REM_W-1:0] den);
      lane_type         r;
      logic [REM_W-1:0] r2;
      r     = l;
      r2    = {l.rem[REM_W-2:0], l.low[DATA_W-1]};
      r.low = {l.low[DATA_W-2:0], 1'b0};
      if (r2 >= den) begin
         r.rem = r2 - den;
         r.q   = {l.q[DATA_W-2:0], 1'b1};
      end else begin
         r.rem = r2;
         r.q   = {l.q[DATA_W-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      data_in    = up_data;
      data_in.re = step(up_data.re, up_data.den);
      data_in.im = step(up_data.im, up_data.den);
   end

   // The stage takes a request when it is empty or its content moves on.
   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end
endmodule

FILE: sv/complex_arith_unit.sv
// Top level of the complex arithmetic unit: add, subtract, multiply and divide in Q16.16.
// The unit takes one request per cycle while the response side does not stall. Each
// request passes through the pipeline: one stage of 32x32 multipliers, one stage of
// sums, one stage that prepares the division and checks for quotient overflow, 32
// restoring-division stages that each give one quotient bit of both parts, and a final
// stage that signs and saturates. Every stage has its own valid bit and takes a new
// request whenever it is empty, so bubbles close up while a response waits. Status is 0
// for ok, 1 when a part saturated and 2 for division by zero, which returns zero parts.
`include "complex_arith_unit_macros.svh"
module complex_arith_unit (
   input logic         clock,
   input logic         reset,
   cau_req_if.sink     req_chan,
   cau_rsp_if.source   rsp_chan
);
   import cau_pkg::*;

   // Saturate a wide signed value to the result range; the top bit flags clamping.
   function automatic logic [DATA_W:0] clamp(logic [SUM_W-1:0] v);
      logic fits;
      fits = (v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1);
      if (fits) begin
         return {1'b0, v[DATA_W-1:0]};
      end
      return {1'b1, (v[SUM_W-1] ? SAT_MIN : SAT_MAX)};
   endfunction

   // Set up one division part: magnitude shifted by the fraction bits.
   function automatic lane_type prep(logic [SUM_W-1:0] v, logic [REM_W-1:0] den);
      lane_type                    l;
      logic [SUM_W-1:0]            mag;
      logic [2*PROD_W-1:0]         x;
      logic [2*PROD_W-DATA_W-1:0]  hi;
      mag   = v[SUM_W-1] ? (~v + 1'b1) : v;
      x     = {{PROD_W{1'b0}}, mag[PROD_W-1:0]} << FRAC_BITS;
      hi    = x[2*PROD_W-1:DATA_W];
      l.neg = v[SUM_W-1];
      l.big = hi >= {{(2*PROD_W-DATA_W-REM_W){1'b0}}, den};
      l.rem = hi[REM_W-1:0];
      l.low = x[DATA_W-1:0];
      l.q   = '0;
      return l;
   endfunction

   // Sign and saturate a finished quotient.
   function automatic logic [DATA_W:0] pack(lane_type l);
      logic sat;
      if (l.neg) begin
         sat = l.big || (l.q[DATA_W-1] && (l.q[DATA_W-2:0] != '0));
         return {sat, (sat ? SAT_MIN : (~l.q + 1'b1))};
      end
      sat = l.big || l.q[DATA_W-1];
      return {sat, (sat ? SAT_MAX : l.q)};
   endfunction

   // Stage 1: partial products and the sums for add and subtract.
   logic                     s1_vld_ff;
   logic                     s1_ready;
   cmd_type                  s1_cmd_ff;
   logic signed [PROD_W-1:0] s1_p_rr_ff, s1_p_ii_ff, s1_p_ri_ff, s1_p_ir_ff;
   logic signed [PROD_W-1:0] s1_p_bbr_ff, s1_p_bbi_ff;
   logic [DATA_W:0]          s1_sum_re_ff, s1_sum_im_ff;
   logic [DATA_W:0]          s1_sum_re_in, s1_sum_im_in;

   // Stage 2: combined numerators and the divisor.
   logic                     s2_vld_ff;
   logic                     s2_ready;
   cmd_type                  s2_cmd_ff;
   logic [SUM_W-1:0]         s2_s_re_ff, s2_s_im_ff;
   logic [SUM_W-1:0]         s2_s_re_in, s2_s_im_in;
   logic [REM_W-1:0]         s2_den_ff;

   // Stage 3: division setup and final values of the other commands.
   logic                     s3_vld_ff;
   logic                     s3_ready;
   div_pipe_type             s3_data_ff;
   div_pipe_type             s3_data_in;
   logic [SUM_W-1:0]         sh_re, sh_im;
   logic [DATA_W:0]          cl_re, cl_im;

   // Divider chain.
   logic                     div_valid [0:DIV_STEPS];
   logic                     div_ready [0:DIV_STEPS];
   div_pipe_type             div_data  [0:DIV_STEPS];

   // Output stage.
   logic                     pack_vld_ff;
   logic                     pack_ready;
   logic [DATA_W-1:0]        pack_re_ff, pack_im_ff;
   logic [DATA_W-1:0]        pack_re_in, pack_im_in;
   status_type               pack_status_ff, pack_status_in;
   logic [DATA_W:0]          pk_re, pk_im;

   // Ready chain: each stage accepts when empty or when its content moves on.
   assign pack_ready     = !pack_vld_ff || rsp_chan.ready;
   assign s3_ready       = !s3_vld_ff || div_ready[0];
   assign s2_ready       = !s2_vld_ff || s3_ready;
   assign s1_ready       = !s1_vld_ff || s2_ready;
   assign req_chan.ready = s1_ready;

   // Stage 1 logic.
   always_comb begin
      if (cmd_type'(req_chan.command) == CMD_SUB) begin
         s1_sum_re_in = {req_chan.a_re[DATA_W-1], req_chan.a_re}
                      - {req_chan.b_re[DATA_W-1], req_chan.b_re};
         s1_sum_im_in = {req_chan.a_im[DATA_W-1], req_chan.a_im}
                      - {req_chan.b_im[DATA_W-1], req_chan.b_im};
      end else begin
         s1_sum_re_in = {req_chan.a_re[DATA_W-1], req_chan.a_re}
                      + {req_chan.b_re[DATA_W-1], req_chan.b_re};
         s1_sum_im_in = {req_chan.a_im[DATA_W-1], req_chan.a_im}
                      + {req_chan.b_im[DATA_W-1], req_chan.b_im};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_chan.valid) begin
         s1_cmd_ff    <= cmd_type'(req_chan.command);
         s1_p_rr_ff   <= req_chan.a_re * req_chan.b_re;
         s1_p_ii_ff   <= req_chan.a_im * req_chan.b_im;
         s1_p_ri_ff   <= req_chan.a_re * req_chan.b_im;
         s1_p_ir_ff   <= req_chan.a_im * req_chan.b_re;
         s1_p_bbr_ff  <= req_chan.b_re * req_chan.b_re;
         s1_p_bbi_ff  <= req_chan.b_im * req_chan.b_im;
         s1_sum_re_ff <= s1_sum_re_in;
         s1_sum_im_ff <= s1_sum_im_in;
      end
   end

   // Stage 2 logic: pick the combination of products for the command.
   always_comb begin
      case (s1_cmd_ff)
         CMD_MUL: begin
            s2_s_re_in = {s1_p_rr_ff[PROD_W-1], s1_p_rr_ff}
                       - {s1_p_ii_ff[PROD_W-1], s1_p_ii_ff};
            s2_s_im_in = {s1_p_ri_ff[PROD_W-1], s1_p_ri_ff}
                       + {s1_p_ir_ff[PROD_W-1], s1_p_ir_ff};
         end
         CMD_DIV: begin
            s2_s_re_in = {s1_p_rr_ff[PROD_W-1], s1_p_rr_ff}
                       + {s1_p_ii_ff[PROD_W-1], s1_p_ii_ff};
            s2_s_im_in = {s1_p_ir_ff[PROD_W-1], s1_p_ir_ff}
                       - {s1_p_ri_ff[PROD_W-1], s1_p_ri_ff};
         end
         default: begin
            s2_s_re_in = {{(SUM_W-DATA_W-1){s1_sum_re_ff[DATA_W]}}, s1_sum_re_ff};
            s2_s_im_in = {{(SUM_W-DATA_W-1){s1_sum_im_ff[DATA_W]}}, s1_sum_im_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_vld_ff) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_s_re_ff <= s2_s_re_in;
         s2_s_im_ff <= s2_s_im_in;
         s2_den_ff  <= REM_W'(s1_p_bbr_ff) + REM_W'(s1_p_bbi_ff);
      end
   end

   // Stage 3 logic: scale and clamp products, or set up the division.
   always_comb begin
      if (s2_cmd_ff == CMD_MUL) begin
         sh_re = SUM_W'($signed(s2_s_re_ff) >>> FRAC_BITS);
         sh_im = SUM_W'($signed(s2_s_im_ff) >>> FRAC_BITS);
      end else begin
         sh_re = s2_s_re_ff;
         sh_im = s2_s_im_ff;
      end
      cl_re               = clamp(sh_re);
      cl_im               = clamp(sh_im);
      s3_data_in.is_div   = (s2_cmd_ff == CMD_DIV);
      s3_data_in.div_zero = (s2_den_ff == '0);
      s3_data_in.fwd_re   = cl_re[DATA_W-1:0];
      s3_data_in.fwd_im   = cl_im[DATA_W-1:0];
      s3_data_in.fwd_sat  = cl_re[DATA_W] | cl_im[DATA_W];
      s3_data_in.den      = s2_den_ff;
      s3_data_in.re       = prep(s2_s_re_ff, s2_den_ff);
      s3_data_in.im       = prep(s2_s_im_ff, s2_den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_vld_ff) begin
         s3_data_ff <= s3_data_in;
      end
   end

   // Divider chain, one quotient bit per stage.
   assign div_valid[0]         = s3_vld_ff;
   assign div_data[0]          = s3_data_ff;
   assign div_ready[DIV_STEPS] = pack_ready;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      cau_div_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (div_valid[k]),
         .up_ready   (div_ready[k]),
         .up_data    (div_data[k]),
         .down_valid (div_valid[k+1]),
         .down_ready (div_ready[k+1]),
         .down_data  (div_data[k+1])
      );
   end

   // Output stage: sign the quotients and form the status.
   always_comb begin
      pk_re = pack(div_data[DIV_STEPS].re);
      pk_im = pack(div_data[DIV_STEPS].im);
      if (!div_data[DIV_STEPS].is_div) begin
         pack_re_in     = div_data[DIV_STEPS].fwd_re;
         pack_im_in     = div_data[DIV_STEPS].fwd_im;
         pack_status_in = div_data[DIV_STEPS].fwd_sat ? STATUS_SAT : STATUS_OK;
      end else if (div_data[DIV_STEPS].div_zero) begin
         pack_re_in     = '0;
         pack_im_in     = '0;
         pack_status_in = STATUS_DIV_ZERO;
      end else begin
         pack_re_in     = pk_re[DATA_W-1:0];
         pack_im_in     = pk_im[DATA_W-1:0];
         pack_status_in = (pk_re[DATA_W] | pk_im[DATA_W]) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_vld_ff <= 1'b0;
      end else if (pack_ready) begin
         pack_vld_ff <= div_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (pack_ready && div_valid[DIV_STEPS]) begin
         pack_re_ff     <= pack_re_in;
         pack_im_ff     <= pack_im_in;
         pack_status_ff <= pack_status_in;
      end
   end

   assign rsp_chan.valid  = pack_vld_ff;
   assign rsp_chan.res_re = pack_re_ff;
   assign rsp_chan.res_im = pack_im_ff;
   assign rsp_chan.status = pack_status_ff;

   // A division by zero returns zero parts.
   `CAU_ASSERT_CLK(a_div_zero_parts, (rsp_chan.valid && rsp_chan.status == STATUS_DIV_ZERO) |-> (rsp_chan.res_re == '0 && rsp_chan.res_im == '0))
   // A saturated response carries a clamped value in at least one part.
   `CAU_ASSERT_CLK(a_sat_value, (rsp_chan.valid && rsp_chan.status == STATUS_SAT) |-> (rsp_chan.res_re == SAT_MAX || rsp_chan.res_re == SAT_MIN || rsp_chan.res_im == SAT_MAX || rsp_chan.res_im == SAT_MIN))
   // Reset empties the pipeline.
   `CAU_ASSERT_RST(a_reset_empty, reset |=> (!rsp_chan.valid && !s1_vld_ff && !s3_vld_ff))
endmodule
